### rtl/ipfmt_pkg.sv
// ----------------------------------------------------------------------------
// ipfmt_pkg
// shared types, character codes and digit helpers of the ip address formatter
// ----------------------------------------------------------------------------
`default_nettype none

package ipfmt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [6:0]  CH_COLON    = 7'h3a;
  localparam logic [6:0]  CH_DOT      = 7'h2e;
  localparam logic [6:0]  CH_ZERO     = 7'h30;
  localparam logic [6:0]  CH_ALPHA    = 7'h57;
  localparam logic [15:0] GRP_MAPPED  = 16'hffff;
  localparam logic [2:0]  GRP_LAST    = 3'd7;
  localparam logic [2:0]  GRP_MAP_TAG = 3'd5;
  localparam logic [2:0]  GRP_V4_HI   = 3'd6;

  // one output unit: leading colons, digits in the shifter, optional suffix
  typedef struct packed {
    logic [1:0]  pre_n;
    logic [2:0]  dig_n;
    logic [15:0] work;
    logic        suf;
    logic        suf_dot;
    logic        fin;
  } plan_t;

  typedef struct packed {
    logic pending;
    logic last_one;
    logic fin;
  } emit_sts_t;

  function automatic logic [11:0] bin2bcd(input logic [7:0] b);
    logic [19:0] sr;
    sr = {12'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (sr[11:8] >= 4'd5) sr[11:8] = sr[11:8] + 4'd3;
      if (sr[15:12] >= 4'd5) sr[15:12] = sr[15:12] + 4'd3;
      if (sr[19:16] >= 4'd5) sr[19:16] = sr[19:16] + 4'd3;
      sr = sr << 1;
    end
    return sr[19:8];
  endfunction

  function automatic logic [2:0] hex_digits(input logic [15:0] v);
    logic [2:0] n;
    if (v[15:12] != 4'd0)     n = 3'd4;
    else if (v[11:8] != 4'd0) n = 3'd3;
    else if (v[7:4] != 4'd0)  n = 3'd2;
    else                      n = 3'd1;
    return n;
  endfunction

  function automatic logic [15:0] hex_align(input logic [15:0] v);
    logic [15:0] w;
    case (hex_digits(v))
      3'd4:    w = v;
      3'd3:    w = {v[11:0], 4'h0};
      3'd2:    w = {v[7:0], 8'h00};
      default: w = {v[3:0], 12'h000};
    endcase
    return w;
  endfunction

  function automatic logic [2:0] dec_digits(input logic [7:0] b);
    logic [2:0] n;
    if (b >= 8'd100)     n = 3'd3;
    else if (b >= 8'd10) n = 3'd2;
    else                 n = 3'd1;
    return n;
  endfunction

  function automatic logic [15:0] dec_align(input logic [7:0] b);
    logic [11:0] bcd;
    logic [15:0] w;
    bcd = bin2bcd(b);
    case (dec_digits(b))
      3'd3:    w = {bcd, 4'h0};
      3'd2:    w = {bcd[7:0], 8'h00};
      default: w = {bcd[3:0], 12'h000};
    endcase
    return w;
  endfunction

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) c = CH_ZERO + {3'd0, d};
    else           c = CH_ALPHA + {3'd0, d};
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/ipfmt_if.sv
// ----------------------------------------------------------------------------
// ipfmt_in_if / ipfmt_out_if
// valid/ready channels for address requests and text characters
// ----------------------------------------------------------------------------
`default_nettype none

interface ipfmt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output op, output addr_high, output addr_low,
                  input ready);
  modport sink   (input valid, input op, input addr_high, input addr_low,
                  output ready);
endinterface

interface ipfmt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

### rtl/ipfmt_emit.sv
// ----------------------------------------------------------------------------
// ipfmt_emit
// character shifter: colons, digits, suffix of one unit, on step one a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ipfmt_emit
  import ipfmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire plan_t     plan,
  input  wire logic      step,
  output emit_sts_t      sts,
  output logic [6:0]     char_out
);

  logic [1:0]  pre_r,  pre_nxt;
  logic [2:0]  dig_r,  dig_nxt;
  logic        suf_r,  suf_nxt;
  logic        dot_r,  dot_nxt;
  logic        fin_r,  fin_nxt;
  logic [15:0] work_r, work_nxt;

  always_comb begin
    pre_nxt  = pre_r;
    dig_nxt  = dig_r;
    suf_nxt  = suf_r;
    dot_nxt  = dot_r;
    fin_nxt  = fin_r;
    work_nxt = work_r;
    if (load) begin
      pre_nxt  = plan.pre_n;
      dig_nxt  = plan.dig_n;
      suf_nxt  = plan.suf;
      dot_nxt  = plan.suf_dot;
      fin_nxt  = plan.fin;
      work_nxt = plan.work;
    end else if (step) begin
      if (pre_r != 2'd0) begin
        pre_nxt = pre_r - 2'd1;
      end else if (dig_r != 3'd0) begin
        dig_nxt  = dig_r - 3'd1;
        work_nxt = {work_r[11:0], 4'h0};
      end else begin
        suf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= '0;
      dig_r <= '0;
      suf_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      pre_r <= pre_nxt;
      dig_r <= dig_nxt;
      suf_r <= suf_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dot_r  <= dot_nxt;
    work_r <= work_nxt;
  end

  always_comb begin
    if (pre_r != 2'd0)      char_out = CH_COLON;
    else if (dig_r != 3'd0) char_out = digit_char(work_r[15:12]);
    else if (dot_r)         char_out = CH_DOT;
    else                    char_out = CH_COLON;
  end

  assign sts.pending  = (pre_r != 2'd0) || (dig_r != 3'd0) || suf_r;
  assign sts.last_one = ((pre_r == 2'd1) && (dig_r == 3'd0) && !suf_r) ||
                        ((pre_r == 2'd0) && (dig_r == 3'd1) && !suf_r) ||
                        ((pre_r == 2'd0) && (dig_r == 3'd0) && suf_r);
  assign sts.fin      = fin_r;

endmodule

`default_nettype wire

### rtl/ip_address_text_formatter_top.sv
// ----------------------------------------------------------------------------
// ip_address_text_formatter_top
// Takes one IPv4 or IPv6 address per request and sends its text form one
// ASCII character per transfer, the final character flagged by last_char.
// IPv6 uses lower-case hex groups, folds the first zero run into '::' and
// writes ::ffff:a.b.c.d for mapped IPv4. A request occupies the block until
// its last character is handed out; the single character shifter gives at most
// one character per cycle, and only when the output register is free, and the
// sequencer visits the groups in turn. A new request is taken as soon as the
// last character sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_text_formatter_top
  import ipfmt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  ipfmt_in_if.sink     in_req,
  ipfmt_out_if.source  out_res
);

  state_t            state_r, state_nxt;
  logic [0:7][15:0]  grp_r;
  logic [2:0]        g_r, g_nxt;
  logic              half_r, half_nxt;
  logic              tail_r, tail_nxt;
  logic              dotted_r, dotted_nxt;
  logic              elided_r, elided_nxt;
  logic              in_run_r, in_run_nxt;
  logic              start0_r, start0_nxt;

  logic              out_valid_r;
  logic [6:0]        out_char_r;
  logic              out_last_r;

  plan_t             plan;
  emit_sts_t         sts;
  logic [6:0]        emit_char;
  logic [15:0]       grp_v;
  logic [7:0]        grp_b;
  logic              in_fire;
  logic              out_free;
  logic              emit_fire;
  logic              load;
  logic              done;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_res.ready;
  assign emit_fire    = (state_r == ST_RUN) && sts.pending && out_free;
  assign done         = emit_fire && sts.last_one && sts.fin;
  assign load         = (state_r == ST_RUN) &&
                        (!sts.pending || (emit_fire && sts.last_one && !sts.fin));

  assign grp_v = grp_r[g_r];
  assign grp_b = half_r ? grp_v[7:0] : grp_v[15:8];

  // unit planner
  always_comb begin
    plan       = '0;
    dotted_nxt = dotted_r;
    elided_nxt = elided_r;
    in_run_nxt = in_run_r;
    start0_nxt = start0_r;
    if (tail_r) begin
      plan.pre_n = 2'd2;
      plan.fin   = 1'b1;
    end else if (dotted_r) begin
      plan.dig_n   = dec_digits(grp_b);
      plan.work    = dec_align(grp_b);
      plan.suf     = !half_r || (g_r == GRP_V4_HI);
      plan.suf_dot = 1'b1;
      plan.fin     = (g_r == GRP_LAST) && half_r;
    end else if (in_run_r && (grp_v != 16'd0)) begin
      plan.pre_n = 2'd2;
      plan.dig_n = hex_digits(grp_v);
      plan.work  = hex_align(grp_v);
      plan.fin   = (g_r == GRP_LAST);
      in_run_nxt = 1'b0;
      if ((g_r == GRP_MAP_TAG) && (grp_v == GRP_MAPPED) && start0_r) begin
        plan.suf   = 1'b1;
        dotted_nxt = 1'b1;
      end
    end else if (in_run_r) begin
      plan = '0;
    end else if (!elided_r && (grp_v == 16'd0)) begin
      elided_nxt = 1'b1;
      in_run_nxt = 1'b1;
      start0_nxt = (g_r == 3'd0);
    end else begin
      plan.pre_n = (g_r != 3'd0) ? 2'd1 : 2'd0;
      plan.dig_n = hex_digits(grp_v);
      plan.work  = hex_align(grp_v);
      plan.fin   = (g_r == GRP_LAST);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    half_nxt  = half_r;
    tail_nxt  = tail_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          g_nxt     = in_req.op ? 3'd0 : GRP_V4_HI;
          half_nxt  = 1'b0;
          tail_nxt  = 1'b0;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end else if (load && !tail_r) begin
          if (dotted_r && !half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            if (g_r == GRP_LAST) tail_nxt = 1'b1;
            else                 g_nxt = g_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      g_r      <= '0;
      half_r   <= 1'b0;
      tail_r   <= 1'b0;
      dotted_r <= 1'b0;
      elided_r <= 1'b0;
      in_run_r <= 1'b0;
      start0_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      g_r     <= g_nxt;
      half_r  <= half_nxt;
      tail_r  <= tail_nxt;
      if (in_fire) begin
        dotted_r <= !in_req.op;
        elided_r <= 1'b0;
        in_run_r <= 1'b0;
        start0_r <= 1'b0;
      end else if (load) begin
        dotted_r <= dotted_nxt;
        elided_r <= elided_nxt;
        in_run_r <= in_run_nxt;
        start0_r <= start0_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      grp_r <= {in_req.addr_high, in_req.addr_low};
    end
  end

  ipfmt_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .plan     (plan),
    .step     (emit_fire),
    .sts      (sts),
    .char_out (emit_char)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_char_r <= emit_char;
      out_last_r <= sts.last_one && sts.fin;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.text_char = out_char_r;
  assign out_res.last_char = out_last_r;

`ifndef NO_ASSERTIONS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.pending)
    else $error("characters left over while idle");

  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN) && !sts.pending)
    else $error("request did not start a clean run");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("final character did not end the request");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !load && !emit_fire)
    else $error("shifter active while idle");
`endif

endmodule

`default_nettype wire
